// ===== sv/modexp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared width constants and transaction types for the modular
// exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;

	localparam int WIDTH = 32;
	localparam int CNT_W = $clog2(WIDTH);

	typedef struct packed {
		logic [WIDTH-1:0] base_value;
		logic [WIDTH-1:0] exponent_value;
		logic [WIDTH-1:0] modulus_value;
	} req_item_t;

	typedef struct packed {
		logic [WIDTH-1:0] power_result;
		logic             bad_modulus;
	} rsp_item_t;

	// modular multiplier status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} mm_status_t;

endpackage
// ----------------------------------------------------------------------------
`default_nettype wire

// ===== sv/modexp_mulmod.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_mulmod
// Bit-serial shift-add modular multiplier: (a * b) mod m, one bit of b per
// cycle, MSB first. Requires a < m and m > 0 (a = 1, m = 1 also works).
// ----------------------------------------------------------------------------
module modexp_mulmod
	import modexp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [WIDTH-1:0] op_a,
	input  wire logic [WIDTH-1:0] op_b,
	input  wire logic [WIDTH-1:0] modulus,
	output mm_status_t            status,
	output logic      [WIDTH-1:0] product
);

	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] b_q;
	logic [WIDTH-1:0] m_q;
	logic [WIDTH-1:0] r_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	// t = 2r + bit*a < 3m; reduce by 2m or m
	logic [WIDTH+1:0] t;
	logic [WIDTH+1:0] m1;
	logic [WIDTH+1:0] m2;
	logic [WIDTH-1:0] r_next;

	always_comb begin
		m1 = {2'b00, m_q};
		m2 = {1'b0, m_q, 1'b0};
		t  = {1'b0, r_q, 1'b0} + (b_q[WIDTH-1] ? {2'b00, a_q} : '0);
		if (t >= m2) begin
			r_next = WIDTH'(t - m2);
		end else if (t >= m1) begin
			r_next = WIDTH'(t - m1);
		end else begin
			r_next = t[WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(WIDTH-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= op_a;
			b_q <= op_b;
			m_q <= modulus;
			r_q <= '0;
		end else if (busy_q) begin
			r_q <= r_next;
			b_q <= {b_q[WIDTH-2:0], 1'b0};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign product     = r_q;

endmodule
// ----------------------------------------------------------------------------
`default_nettype wire

// ===== sv/modular_exponentiation.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation
// Left-to-right square-and-multiply modular exponentiation, bit-serial.
// ----------------------------------------------------------------------------
// Computes base^exponent mod modulus over WIDTH-bit unsigned operands. One
// transaction at a time: the request side stalls while a transaction is in
// flight, but a new request is taken while the previous result still waits
// in the response register. Every step runs on one shared bit-serial modular
// multiplier that loads its operands and then takes one bit of b per cycle.
// A transaction costs the base reduction, WIDTH squarings and one multiply
// per set exponent bit. A zero modulus skips the multiplier and goes straight
// to the output state, answered with bad_modulus set and result 0; a modulus
// of one yields 0.
// ----------------------------------------------------------------------------
module modular_exponentiation
	import modexp_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire req_item_t req_data,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output rsp_item_t      rsp_data
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_RED  = 5'b00010,  // reducing base by modulus
		S_SQR  = 5'b00100,  // squaring accumulator
		S_MUL  = 5'b01000,  // multiplying by base
		S_OUT  = 5'b10000   // waiting for response register
	} state_t;

	localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

	state_t           state_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] exp_q;
	logic [WIDTH-1:0] base_q;
	logic [WIDTH-1:0] mod_q;
	logic             bad_q;
	logic [CNT_W-1:0] cnt_q;
	logic             rsp_valid_q;
	rsp_item_t        rsp_q;

	logic             accept;
	logic             last_bit;
	logic             load_rsp;
	logic             mm_start;
	logic [WIDTH-1:0] mm_a;
	logic [WIDTH-1:0] mm_b;
	logic [WIDTH-1:0] mm_m;
	logic [WIDTH-1:0] mm_prod;
	mm_status_t       mm_stat;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign last_bit  = (cnt_q == CNT_W'(WIDTH-1));
	assign load_rsp  = (state_q == S_OUT) && (!rsp_valid_q || !rsp_stall);

	// operand select for the next multiplier pass
	always_comb begin
		mm_start = 1'b0;
		mm_a     = mm_prod;
		mm_b     = mm_prod;
		mm_m     = mod_q;
		case (state_q)
			S_IDLE: begin
				// base mod m computed as (1 * base) mod m
				mm_a     = ONE;
				mm_b     = req_data.base_value;
				mm_m     = req_data.modulus_value;
				mm_start = accept && (req_data.modulus_value != '0);
			end
			S_RED: begin
				mm_a     = acc_q;
				mm_b     = acc_q;
				mm_start = mm_stat.done;
			end
			S_SQR: begin
				if (exp_q[WIDTH-1]) begin
					mm_b     = base_q;
					mm_start = mm_stat.done;
				end else begin
					mm_start = mm_stat.done && !last_bit;
				end
			end
			S_MUL: begin
				mm_start = mm_stat.done && !last_bit;
			end
			default: begin
				mm_start = 1'b0;
			end
		endcase
	end

	modexp_mulmod u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mm_start),
		.op_a    (mm_a),
		.op_b    (mm_b),
		.modulus (mm_m),
		.status  (mm_stat),
		.product (mm_prod)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						state_q <= (req_data.modulus_value == '0) ? S_OUT : S_RED;
					end
				end
				S_RED: begin
					if (mm_stat.done) begin
						state_q <= S_SQR;
					end
				end
				S_SQR: begin
					if (mm_stat.done) begin
						if (exp_q[WIDTH-1]) begin
							state_q <= S_MUL;
						end else begin
							cnt_q   <= cnt_q + 1'b1;
							state_q <= last_bit ? S_OUT : S_SQR;
						end
					end
				end
				S_MUL: begin
					if (mm_stat.done) begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= last_bit ? S_OUT : S_SQR;
					end
				end
				S_OUT: begin
					if (load_rsp) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					mod_q <= req_data.modulus_value;
					exp_q <= req_data.exponent_value;
					bad_q <= (req_data.modulus_value == '0);
					// 1 mod m: zero for m of zero or one
					acc_q <= (req_data.modulus_value > ONE) ? ONE : '0;
				end
			end
			S_RED: begin
				if (mm_stat.done) begin
					base_q <= mm_prod;
				end
			end
			S_SQR: begin
				if (mm_stat.done) begin
					acc_q <= mm_prod;
					if (!exp_q[WIDTH-1]) begin
						exp_q <= {exp_q[WIDTH-2:0], 1'b0};
					end
				end
			end
			S_MUL: begin
				if (mm_stat.done) begin
					acc_q <= mm_prod;
					exp_q <= {exp_q[WIDTH-2:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q.power_result <= acc_q;
			rsp_q.bad_modulus  <= bad_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// multiplier is only started when free
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mm_start |-> !mm_stat.busy)
		else $error("multiplier started while busy");

	// reduced base lies below the modulus
	a_base_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RED) && mm_stat.done |=> base_q < mod_q)
		else $error("base not reduced");

	// accumulator stays reduced during the scan
	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQR) || (state_q == S_MUL) |-> acc_q < mod_q)
		else $error("accumulator not reduced");

	// zero modulus goes straight to the response with the flag set
	a_zero_mod: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req_data.modulus_value == '0) |=> (state_q == S_OUT) && bad_q)
		else $error("zero modulus not flagged");

endmodule
// ----------------------------------------------------------------------------
`default_nettype wire
